[rtl/bdt_pkg.sv]
`default_nettype none

package bdt_pkg;

  // width used for all dimension compares (holds up to 2047)
  localparam int unsigned DIMW = 11;

  // distance field and cell word layout: source, unreached, distance
  localparam int unsigned DIST_W   = 9;
  localparam int unsigned CELL_W   = 11;
  localparam int unsigned CELL_UNR = 9;
  localparam int unsigned CELL_SRC = 10;
  localparam logic [DIST_W-1:0] DIST_SAT = 9'd511;

  // configuration register width and index width
  localparam int unsigned CFG_DW = 9;
  localparam int unsigned CFG_IW = 1;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_WALK = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_INIT,
    ST_INIT_END,
    ST_POP,
    ST_CTR,
    ST_CWAIT,
    ST_NBR,
    ST_DONE
  } state_e;

  // neighbor visit order
  typedef enum logic [2:0] {
    NB_LEFT  = 3'd0,
    NB_RIGHT = 3'd1,
    NB_UP    = 3'd2,
    NB_DOWN  = 3'd3,
    NB_END   = 3'd4
  } nb_e;

  // one result word handed to the output register
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              unreached;
    logic              done_res;
  } res_t;

endpackage

`default_nettype wire

[rtl/bdt_ram.sv]
`default_nettype none

module bdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/bdt_ctrl.sv]
`default_nettype none

module bdt_ctrl
  import bdt_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256,
  localparam int unsigned RW   = $clog2(MAX_ROWS),
  localparam int unsigned CW   = $clog2(MAX_COLS),
  localparam int unsigned AW   = RW + CW,
  localparam int unsigned QAW  = $clog2(MAX_ROWS * MAX_COLS),
  localparam int unsigned RCW  = $clog2(MAX_ROWS + 1),
  localparam int unsigned CCW  = $clog2(MAX_COLS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request side
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        in_req_i,
  input  wire logic [7:0]        in_row_i,
  input  wire logic [7:0]        in_col_i,
  input  wire logic              in_pixel_i,
  // active region
  input  wire logic [RCW-1:0]    row_count_i,
  input  wire logic [CCW-1:0]    col_count_i,
  // result side
  output logic                   res_valid_o,
  output res_t                   res_o,
  input  wire logic              res_free_i,
  // cell memory
  output logic                   cell_we_o,
  output logic [AW-1:0]          cell_waddr_o,
  output logic [CELL_W-1:0]      cell_wdata_o,
  output logic [AW-1:0]          cell_raddr_o,
  input  wire logic [CELL_W-1:0] cell_rdata_i,
  // frontier queue memory
  output logic                   q_we_o,
  output logic [QAW-1:0]         q_waddr_o,
  output logic [AW-1:0]          q_wdata_o,
  output logic [QAW-1:0]         q_raddr_o,
  input  wire logic [AW-1:0]     q_rdata_i
);

  localparam int unsigned QCW = $clog2(MAX_ROWS * MAX_COLS + 1);

  state_e            state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic              px_q, px_d;
  logic              oor_q, oor_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  nb_e               nb_q, nb_d;
  logic [DIST_W-1:0] nd_q, nd_d;
  logic [QCW-1:0]    head_q, head_d;
  logic [QCW-1:0]    tail_q, tail_d;

  logic              in_arr_ok;
  logic              in_region;
  logic [AW-1:0]     in_addr;
  logic [AW-1:0]     cur_addr;
  logic              last_col;
  logic              last_row;
  logic              nb_ok;
  logic [RW-1:0]     nb_row;
  logic [CW-1:0]     nb_col;
  logic [AW-1:0]     nb_addr;
  logic [DIST_W-1:0] ctr_dist;
  logic [DIST_W-1:0] nd_next;
  logic              q_empty;

  // request address checks
  assign in_arr_ok = (DIMW'(in_row_i) < DIMW'(MAX_ROWS)) && (DIMW'(in_col_i) < DIMW'(MAX_COLS));
  assign in_region = (DIMW'(in_row_i) < DIMW'(row_count_i))
                  && (DIMW'(in_col_i) < DIMW'(col_count_i));
  assign in_addr   = {RW'(in_row_i), CW'(in_col_i)};
  assign cur_addr  = {row_q, col_q};

  // raster sweep end detection
  assign last_col = (DIMW'(col_q) + DIMW'(1)) == DIMW'(col_count_i);
  assign last_row = (DIMW'(row_q) + DIMW'(1)) == DIMW'(row_count_i);

  // next distance, saturating
  assign ctr_dist = cell_rdata_i[DIST_W-1:0];
  assign nd_next  = (ctr_dist == DIST_SAT) ? DIST_SAT : ctr_dist + DIST_W'(1);
  assign q_empty  = (head_q == tail_q);

  // neighbor address and bounds
  always_comb begin
    nb_ok  = 1'b0;
    nb_row = row_q;
    nb_col = col_q;
    case (nb_q)
      NB_LEFT: begin
        nb_ok  = (col_q != '0);
        nb_col = col_q - CW'(1);
      end
      NB_RIGHT: begin
        nb_ok  = (DIMW'(col_q) + DIMW'(1)) < DIMW'(col_count_i);
        nb_col = col_q + CW'(1);
      end
      NB_UP: begin
        nb_ok  = (row_q != '0);
        nb_row = row_q - RW'(1);
      end
      NB_DOWN: begin
        nb_ok  = (DIMW'(row_q) + DIMW'(1)) < DIMW'(row_count_i);
        nb_row = row_q + RW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_addr = {nb_row, nb_col};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_e'(in_req_i))
            REQ_LOAD: begin
              if (in_arr_ok) state_d = ST_LOAD;
            end
            REQ_WALK: state_d = ST_INIT;
            REQ_READ: state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:     state_d = ST_IDLE;
      ST_READ: begin
        if (res_free_i) state_d = ST_IDLE;
      end
      ST_INIT: begin
        if (last_col && last_row) state_d = ST_INIT_END;
      end
      ST_INIT_END: state_d = ST_POP;
      ST_POP:      state_d = q_empty ? ST_DONE : ST_CTR;
      ST_CTR:      state_d = ST_CWAIT;
      ST_CWAIT:    state_d = ST_NBR;
      ST_NBR: begin
        if (nb_q == NB_END) state_d = ST_POP;
      end
      ST_DONE: begin
        if (res_free_i) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    px_d         = px_q;
    oor_d        = oor_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    nb_d         = nb_q;
    nd_d         = nd_q;
    head_d       = head_q;
    tail_d       = tail_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    cell_we_o    = 1'b0;
    cell_waddr_o = pend_addr_q;
    cell_wdata_o = '0;
    cell_raddr_o = cur_addr;
    q_we_o       = 1'b0;
    q_waddr_o    = tail_q[QAW-1:0];
    q_wdata_o    = pend_addr_q;
    q_raddr_o    = head_q[QAW-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cell_raddr_o = in_addr;
        if (in_valid_i) begin
          row_d = RW'(in_row_i);
          col_d = CW'(in_col_i);
          px_d  = in_pixel_i;
          oor_d = !in_region;
          if (req_e'(in_req_i) == REQ_WALK) begin
            row_d  = '0;
            col_d  = '0;
            head_d = '0;
            tail_d = '0;
            pend_d = 1'b0;
          end
        end
      end
      // keep the unreached and distance bits, replace the source bit
      ST_LOAD: begin
        cell_we_o    = 1'b1;
        cell_waddr_o = cur_addr;
        cell_wdata_o = {px_q, cell_rdata_i[CELL_UNR:0]};
      end
      ST_READ: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          if (oor_q || cell_rdata_i[CELL_UNR]) begin
            res_o.unreached = 1'b1;
          end else begin
            res_o.distance = cell_rdata_i[DIST_W-1:0];
          end
        end
      end
      // seed sweep: one read and one write-back per cycle
      ST_INIT, ST_INIT_END: begin
        if (pend_q) begin
          cell_we_o    = 1'b1;
          cell_wdata_o = {cell_rdata_i[CELL_SRC], !cell_rdata_i[CELL_SRC], DIST_W'(0)};
          if (cell_rdata_i[CELL_SRC]) begin
            q_we_o = 1'b1;
            tail_d = tail_q + QCW'(1);
          end
        end
        if (state_q == ST_INIT) begin
          pend_d      = 1'b1;
          pend_addr_d = cur_addr;
          if (last_col) begin
            col_d = '0;
            if (!last_row) row_d = row_q + RW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_POP: begin
        if (!q_empty) head_d = head_q + QCW'(1);
      end
      ST_CTR: begin
        row_d        = q_rdata_i[AW-1:CW];
        col_d        = q_rdata_i[CW-1:0];
        cell_raddr_o = q_rdata_i;
      end
      ST_CWAIT: begin
        nd_d   = nd_next;
        nb_d   = NB_LEFT;
        pend_d = 1'b0;
      end
      // check the neighbor read last cycle, issue the next one
      ST_NBR: begin
        if (pend_q && cell_rdata_i[CELL_UNR]) begin
          cell_we_o    = 1'b1;
          cell_wdata_o = {cell_rdata_i[CELL_SRC], 1'b0, nd_q};
          q_we_o       = 1'b1;
          tail_d       = tail_q + QCW'(1);
        end
        if (nb_q == NB_END) begin
          pend_d = 1'b0;
        end else begin
          nb_d         = nb_e'(nb_q + 3'd1);
          pend_d       = nb_ok;
          pend_addr_d  = nb_addr;
          cell_raddr_o = nb_addr;
        end
      end
      ST_DONE: begin
        if (res_free_i) begin
          res_valid_o    = 1'b1;
          res_o.done_res = 1'b1;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      nb_q    <= NB_LEFT;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      nb_q    <= nb_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    px_q        <= px_d;
    oor_q       <= oor_d;
    pend_addr_q <= pend_addr_d;
    nd_q        <= nd_d;
  end

endmodule

`default_nettype wire

[rtl/bitmap_distance_transform.sv]
// Multi-source distance transform over a binary bitmap of up to MAX_ROWS x MAX_COLS.
// Input stream (s_axis): tuser selects the request (load pixel, run walk, read distance),
// tdata carries row, column and pixel value. A load stores one pixel and gives no word out.
// A walk seeds every set pixel of the active region at distance 0 and runs a breadth-first
// walk over the 4-neighbour grid; it ends with one word out with tuser done_res set.
// A read gives one word out: the stored distance, or unreached for pixels outside the
// region or not reached by any source. Distances saturate at 511.
// Output stream (m_axis) is a single output register; a stalled receiver holds the word,
// and the block keeps accepting loads while it waits, but a read or walk stalls at its end
// until the register frees.
// Steps: a walk runs a seed sweep over the region, then per reached pixel, sources included,
// a queue pop, center read and wait, four neighbour reads and a last write-back through the
// one-read, one-write cell memory. One request is in flight at a time.
// Configuration: cfg_we_i writes row_count (index 0) or col_count (index 1) at once;
// 0 is taken as 1 and values above the maximum saturate. Write only while idle.
// Reset: control state and counts return to their defaults; memory content is kept
// and no clearing pass runs, so read or walk only after loading the pixels in use.
`default_nettype none

module bitmap_distance_transform
  import bdt_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  // request words
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [23:0]       s_axis_tdata,  // row[7:0], col[15:8], pixel[16], zero pad
  input  wire logic [1:0]        s_axis_tuser,  // req_type[1:0]
  // result words
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // distance[8:0], unreached[9], zero pad
  output logic [0:0]             m_axis_tuser   // done_res[0]
);

  localparam int unsigned RW         = $clog2(MAX_ROWS);
  localparam int unsigned CW         = $clog2(MAX_COLS);
  localparam int unsigned AW         = RW + CW;
  localparam int unsigned CELL_DEPTH = MAX_ROWS * (2 ** CW);
  localparam int unsigned CELLS      = MAX_ROWS * MAX_COLS;
  localparam int unsigned QAW        = $clog2(CELLS);
  localparam int unsigned RCW        = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW        = $clog2(MAX_COLS + 1);
  localparam int unsigned RST_ROWS   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int unsigned RST_COLS   = (MAX_COLS < 256) ? MAX_COLS : 256;

  logic [RCW-1:0]    row_count_q, row_count_d;
  logic [CCW-1:0]    col_count_q, col_count_d;
  logic              m_valid_q, m_valid_d;
  res_t              m_res_q, m_res_d;
  logic              res_free;
  logic              res_valid;
  res_t              res;

  logic              cell_we;
  logic [AW-1:0]     cell_waddr;
  logic [CELL_W-1:0] cell_wdata;
  logic [AW-1:0]     cell_raddr;
  logic [CELL_W-1:0] cell_rdata;
  logic              q_we;
  logic [QAW-1:0]    q_waddr;
  logic [AW-1:0]     q_wdata;
  logic [QAW-1:0]    q_raddr;
  logic [AW-1:0]     q_rdata;

  // configuration writes with clamping
  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_ROW_COUNT: begin
          if (cfg_data_i == '0) begin
            row_count_d = RCW'(1);
          end else if (DIMW'(cfg_data_i) > DIMW'(MAX_ROWS)) begin
            row_count_d = RCW'(MAX_ROWS);
          end else begin
            row_count_d = RCW'(cfg_data_i);
          end
        end
        CFG_COL_COUNT: begin
          if (cfg_data_i == '0) begin
            col_count_d = CCW'(1);
          end else if (DIMW'(cfg_data_i) > DIMW'(MAX_COLS)) begin
            col_count_d = CCW'(MAX_COLS);
          end else begin
            col_count_d = CCW'(cfg_data_i);
          end
        end
        default: begin
          row_count_d = row_count_q;
        end
      endcase
    end
  end

  // output register
  assign res_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
      m_res_d   = res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RCW'(RST_ROWS);
      col_count_q <= CCW'(RST_COLS);
      m_valid_q   <= 1'b0;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_res_q.unreached, m_res_q.distance};
  assign m_axis_tuser  = m_res_q.done_res;

  // request sequencer
  bdt_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_req_i     (s_axis_tuser),
    .in_row_i     (s_axis_tdata[7:0]),
    .in_col_i     (s_axis_tdata[15:8]),
    .in_pixel_i   (s_axis_tdata[16]),
    .row_count_i  (row_count_q),
    .col_count_i  (col_count_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_free_i   (res_free),
    .cell_we_o    (cell_we),
    .cell_waddr_o (cell_waddr),
    .cell_wdata_o (cell_wdata),
    .cell_raddr_o (cell_raddr),
    .cell_rdata_i (cell_rdata),
    .q_we_o       (q_we),
    .q_waddr_o    (q_waddr),
    .q_wdata_o    (q_wdata),
    .q_raddr_o    (q_raddr),
    .q_rdata_i    (q_rdata)
  );

  // cell memory: source bit, unreached bit, distance
  bdt_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  // frontier queue of pixel addresses
  bdt_ram #(
    .WIDTH (AW),
    .DEPTH (CELLS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

endmodule

`default_nettype wire

[verif/bitmap_distance_transform_test.sv]
module bitmap_distance_transform_test;
  import bdt_pkg::*;

  localparam int unsigned GRID_ROWS = 256;
  localparam int unsigned GRID_COLS = 256;
  localparam int unsigned CELLS = GRID_ROWS * GRID_COLS;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 75;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;
  logic s_valid;
  wire logic s_ready;
  logic [23:0] s_data;  // row[7:0], col[15:8], pixel[16], zero pad
  logic [1:0] s_user;   // req_type[1:0]
  wire logic m_valid;
  logic m_ready = 1'b0;
  wire logic [15:0] m_data;  // distance[8:0], unreached[9], zero pad
  wire logic [0:0] m_user;   // done_res[0]

  // predictor state: loaded bitmap, stored distances and walk bookkeeping
  int unsigned active_rows = GRID_ROWS;
  int unsigned active_cols = GRID_COLS;
  bit src_map [CELLS];
  bit src_ok [CELLS];
  logic [15:0] dist_mem [CELLS];
  bit dist_ok [CELLS];
  bit seen [CELLS];
  int unsigned frontier [CELLS];
  int unsigned frontier_tail;
  res_t awaited_results [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 53;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int unsigned cycle_count = 0;

  always #1 clk_i = ~clk_i;

  bitmap_distance_transform dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  // register value as the block takes it: zero means one, saturate at the grid size
  function automatic int unsigned fit_dim(logic [CFG_DW-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // first arrival at a pixel fixes its distance
  function automatic void reach_cell(int unsigned idx, logic [15:0] d);
    if (seen[idx] || src_map[idx]) return;
    seen[idx] = 1'b1;
    dist_mem[idx] = d;
    frontier[frontier_tail] = idx;
    frontier_tail++;
  endfunction

  // multi-source breadth-first walk over the active region
  function automatic void walk_distances();
    int unsigned head, idx, pr, pc;
    logic [15:0] nd;
    head = 0;
    frontier_tail = 0;
    for (int unsigned r = 0; r < active_rows; r++) begin
      for (int unsigned c = 0; c < active_cols; c++) begin
        idx = r * GRID_COLS + c;
        dist_ok[idx] = 1'b1;
        if (src_map[idx]) begin
          dist_mem[idx] = 16'd0;
          seen[idx] = 1'b1;
          frontier[frontier_tail] = idx;
          frontier_tail++;
        end else begin
          dist_mem[idx] = 16'h8000;
          seen[idx] = 1'b0;
        end
      end
    end
    while (head < frontier_tail) begin
      idx = frontier[head];
      head++;
      pr = idx / GRID_COLS;
      pc = idx % GRID_COLS;
      nd = {1'b0, dist_mem[idx][14:0]} + 16'd1;
      if (pc > 0) reach_cell(idx - 1, nd);
      if (pc + 1 < active_cols) reach_cell(idx + 1, nd);
      if (pr > 0) reach_cell(idx - GRID_COLS, nd);
      if (pr + 1 < active_rows) reach_cell(idx + GRID_COLS, nd);
    end
  endfunction

  // distance word for one pixel read
  function automatic res_t read_distance(logic [7:0] row, logic [7:0] col);
    res_t res;
    logic [15:0] v;
    res.distance = '0;
    res.unreached = 1'b1;
    res.done_res = 1'b0;
    if (row < active_rows && col < active_cols) begin
      v = dist_mem[row * GRID_COLS + col];
      if (!v[15]) begin
        res.unreached = 1'b0;
        res.distance = (v[14:0] > 15'd511) ? DIST_SAT : v[8:0];
      end
    end
    return res;
  endfunction

  // update the predicted state for one accepted request
  function automatic void apply_request(logic [1:0] kind, logic [7:0] row, logic [7:0] col,
                                        logic px);
    case (kind)
      REQ_LOAD: begin
        src_map[row * GRID_COLS + col] = px;
        src_ok[row * GRID_COLS + col] = 1'b1;
        items_sent++;
      end
      REQ_WALK: begin
        walk_distances();
        awaited_results.push_back('{distance: '0, unreached: 1'b0, done_res: 1'b1});
        items_sent++;
      end
      REQ_READ: begin
        awaited_results.push_back(read_distance(row, col));
        items_sent++;
      end
      default: begin
      end
    endcase
  endfunction

  // offer one request word and wait for it to be taken
  task automatic send_word(logic [1:0] kind, logic [7:0] row, logic [7:0] col, logic px);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= kind;
    s_data <= {7'd0, px, col, row};
    do @(posedge clk_i); while (!s_ready);
    apply_request(kind, row, col, px);
  endtask

  // drop valid and wait until the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both region registers while the block is idle
  task automatic set_region(logic [CFG_DW-1:0] rows_val, logic [CFG_DW-1:0] cols_val);
    settle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ROW_COUNT;
    cfg_data <= rows_val;
    @(negedge clk_i);
    cfg_idx <= CFG_COL_COUNT;
    cfg_data <= cols_val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    active_rows = fit_dim(rows_val, GRID_ROWS);
    active_cols = fit_dim(cols_val, GRID_COLS);
  endtask

  // load every pixel of the region not loaded yet, and some others again
  task automatic load_region(int src_pct, int reload_pct);
    int unsigned idx;
    for (int unsigned r = 0; r < active_rows; r++) begin
      for (int unsigned c = 0; c < active_cols; c++) begin
        idx = r * GRID_COLS + c;
        if (!src_ok[idx] || $urandom_range(0, 99) < reload_pct)
          send_word(REQ_LOAD, 8'(r), 8'(c), $urandom_range(0, 99) < src_pct);
      end
    end
  endtask

  // random reads; pixels in the region are read only once a walk has set them
  task automatic read_pixels(int count, int inside_pct);
    int unsigned r, c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < inside_pct) begin
        r = $urandom_range(0, active_rows - 1);
        c = $urandom_range(0, active_cols - 1);
      end else begin
        r = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
      end
      if (r < active_rows && c < active_cols && !dist_ok[r * GRID_COLS + c]) continue;
      send_word(REQ_READ, 8'(r), 8'(c), 1'($urandom_range(0, 1)));
    end
  endtask

  // every request kind and the corner cases on a 2x2 region
  task automatic test_basic_requests();
    set_region(9'd2, 9'd2);
    send_word(REQ_LOAD, 8'd0, 8'd0, 1'b1);
    send_word(REQ_LOAD, 8'd0, 8'd1, 1'b0);
    send_word(REQ_LOAD, 8'd1, 8'd0, 1'b0);
    send_word(REQ_LOAD, 8'd1, 8'd1, 1'b0);
    // stored although outside the region
    send_word(REQ_LOAD, 8'hFF, 8'hFF, 1'b1);
    // unknown request is dropped
    send_word(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_word(REQ_WALK, 8'd0, 8'd0, 1'b0);
    send_word(REQ_READ, 8'd0, 8'd0, 1'b0);
    send_word(REQ_READ, 8'd1, 8'd1, 1'b1);
    send_word(REQ_READ, 8'd0, 8'd1, 1'b0);
    // reads outside the region
    send_word(REQ_READ, 8'd2, 8'd0, 1'b0);
    send_word(REQ_READ, 8'hFF, 8'hFF, 1'b1);
    send_word(REQ_READ, 8'd0, 8'hFF, 1'b0);
    // no source left: everything unreached
    send_word(REQ_LOAD, 8'd0, 8'd0, 1'b0);
    send_word(REQ_LOAD, 8'd0, 8'd1, 1'b0);
    send_word(REQ_LOAD, 8'd1, 8'd0, 1'b0);
    send_word(REQ_LOAD, 8'd1, 8'd1, 1'b0);
    send_word(REQ_WALK, 8'hFF, 8'hFF, 1'b1);
    send_word(REQ_READ, 8'd1, 8'd0, 1'b0);
    send_word(REQ_READ, 8'd0, 8'd0, 1'b1);
  endtask

  // register clamping and the widest single row and column regions
  task automatic test_dim_extremes();
    set_region(9'd0, 9'h1FF);
    load_region(3, 0);
    send_word(REQ_WALK, 8'd0, 8'd0, 1'b0);
    read_pixels(16, 80);
    set_region(9'd300, 9'd1);
    load_region(3, 0);
    send_word(REQ_WALK, 8'd0, 8'd0, 1'b0);
    read_pixels(16, 80);
    set_region(9'd256, 9'd2);
    load_region(2, 10);
    send_word(REQ_WALK, 8'd0, 8'd0, 1'b0);
    read_pixels(16, 80);
  endtask

  // bitmaps of random small sizes: load, walk, read, with some noise between
  task automatic test_random_frames(int target);
    int stop;
    logic [CFG_DW-1:0] rows_val, cols_val;
    stop = items_sent + target;
    while (items_sent < stop) begin
      if ($urandom_range(0, 3) != 0) begin
        rows_val = 9'($urandom_range(1, 8));
        cols_val = 9'($urandom_range(1, 8));
        if ($urandom_range(0, 7) == 0) rows_val = 9'($urandom_range(9, 24));
        if ($urandom_range(0, 7) == 0) cols_val = 9'($urandom_range(9, 24));
        if ($urandom_range(0, 15) == 0) rows_val = '0;
        if ($urandom_range(0, 15) == 0) cols_val = '0;
        set_region(rows_val, cols_val);
      end
      load_region($urandom_range(0, 40), $urandom_range(0, 60));
      if ($urandom_range(0, 5) == 0)
        send_word(REQ_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0)
        send_word(REQ_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) != 0)
        send_word(REQ_WALK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      read_pixels($urandom_range(2, 10), 80);
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    set_region(9'd4, 9'd4);
    load_region(30, 20);
    send_word(REQ_WALK, 8'd0, 8'd0, 1'b0);
    hold_requests++;
    read_pixels(10, 100);
    send_word(REQ_LOAD, 8'd3, 8'd3, 1'b1);
    send_word(REQ_WALK, 8'd0, 8'd0, 1'b0);
    read_pixels(6, 90);
    settle();
  endtask

  // receiver side: random ready, or a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, got distance %0d unreached %0b done %0b",
                 $time, m_data[8:0], m_data[9], m_user[0]);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (m_data[8:0] !== want.distance) begin
          $display("%0t: distance mismatch: expected %0d, got %0d",
                   $time, want.distance, m_data[8:0]);
          mismatch_count++;
        end
        if (m_data[9] !== want.unreached) begin
          $display("%0t: unreached mismatch: expected %0b, got %0b",
                   $time, want.unreached, m_data[9]);
          mismatch_count++;
        end
        if (m_user[0] !== want.done_res) begin
          $display("%0t: done_res mismatch: expected %0b, got %0b",
                   $time, want.done_res, m_user[0]);
          mismatch_count++;
        end
      end
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_ROW_COUNT;
    cfg_data = '0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = REQ_LOAD;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles little, receiver often
    send_idle_pct = 13;
    recv_idle_pct = 53;
    test_basic_requests();
    test_dim_extremes();
    test_random_frames(PHASE_ITEMS);
    test_output_backpressure();

    // sender idles often, receiver little
    send_idle_pct = 53;
    recv_idle_pct = 13;
    test_random_frames(PHASE_ITEMS);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(PHASE_ITEMS);
    test_output_backpressure();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
